### hw/rtl/deadline_sorted_timer_queue_top_assert.svh
// assertion macros shared by the checker
`ifndef DEADLINE_SORTED_TIMER_QUEUE_TOP_ASSERT_SVH
`define DEADLINE_SORTED_TIMER_QUEUE_TOP_ASSERT_SVH

// same-cycle implication under reset
`define DSTQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dstq assertion failed");

// next-cycle implication under reset
`define DSTQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dstq assertion failed");

`endif

### hw/rtl/dstq_pkg.sv
package dstq_pkg;

	localparam int ID_W      = 4;
	localparam int FIELD_W   = 48;
	localparam int MAX_FIRED = 16;
	localparam int FCNT_W    = 5;

	localparam logic [1:0] KIND_ABS  = 2'd0;
	localparam logic [1:0] KIND_REL  = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic [ID_W-1:0]    task_id;
		logic [FIELD_W-1:0] time_value;
	} req_t;

	typedef struct packed {
		logic               fired_valid;
		logic [ID_W-1:0]    fired_task;
		logic               last;
		logic [FIELD_W-1:0] next_deadline;
		logic               queue_empty;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_INSERT,
		ST_ADVANCE,
		ST_POP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic remove;
		logic insert;
		logic advance;
		logic pop;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic head_due;
		logic emit_last;
	} stat_t;

endpackage

### hw/rtl/deadline_sorted_timer_queue_top.sv
// channel   ports                       handshake
// request   start, busy, req            taken when start high and busy low
// result    result_valid, result        one-cycle strobe, no back-pressure
//
// schedule: capture, remove old entry, insert, result
// tick: capture, advance clock, pop due tasks, then a result per fired task; one pop per cycle
// kind three: capture, then a status result; the controller fsm sets all of these
// reset clears the entry count, clock and control; entries are not cleared
// results cannot be held off; each shows for exactly one cycle
module deadline_sorted_timer_queue_top #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TIME_WIDTH  = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dstq_pkg::req_t    req,
	output logic              result_valid,
	output dstq_pkg::rsp_t    result
);

	dstq_pkg::cmd_t  cmd;
	dstq_pkg::stat_t stat;

	// sequencer
	dstq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (req.kind),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// queue, clock and result register
	dstq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

### hw/rtl/dstq_ctrl.sv
module dstq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        kind,
	input  dstq_pkg::stat_t   stat,
	output logic              busy,
	output dstq_pkg::cmd_t    cmd
);

	dstq_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dstq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			dstq_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					if (kind == dstq_pkg::KIND_ABS || kind == dstq_pkg::KIND_REL) begin
						state_d = dstq_pkg::ST_REMOVE;
					end else if (kind == dstq_pkg::KIND_TICK) begin
						state_d = dstq_pkg::ST_ADVANCE;
					end else begin
						state_d = dstq_pkg::ST_EMIT;
					end
				end
			end
			dstq_pkg::ST_REMOVE: begin
				cmd.remove = 1'b1;
				state_d    = dstq_pkg::ST_INSERT;
			end
			dstq_pkg::ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = dstq_pkg::ST_EMIT;
			end
			dstq_pkg::ST_ADVANCE: begin
				cmd.advance = 1'b1;
				state_d     = dstq_pkg::ST_POP;
			end
			dstq_pkg::ST_POP: begin
				if (stat.head_due) begin
					cmd.pop = 1'b1;
				end else begin
					state_d = dstq_pkg::ST_EMIT;
				end
			end
			dstq_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
				if (stat.emit_last) begin
					state_d = dstq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dstq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/dstq_datapath.sv
module dstq_datapath #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TIME_WIDTH  = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dstq_pkg::req_t    req,
	input  dstq_pkg::cmd_t    cmd,
	output dstq_pkg::stat_t   stat,
	output logic              result_valid,
	output dstq_pkg::rsp_t    result
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ID_W  = dstq_pkg::ID_W;
	localparam int FW    = dstq_pkg::FIELD_W;
	localparam int FC_W  = dstq_pkg::FCNT_W;

	logic [TIME_WIDTH-1:0] dl_q [QUEUE_DEPTH];
	logic [ID_W-1:0]       id_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]      count_q;
	logic [TIME_WIDTH-1:0] time_q;
	logic [1:0]            kind_q;
	logic [ID_W-1:0]       req_id_q;
	logic [TIME_WIDTH-1:0] req_tv_q;
	logic [TIME_WIDTH-1:0] sched_dl_q;
	logic [ID_W-1:0]       fired_q [dstq_pkg::MAX_FIRED];
	logic [FC_W-1:0]       fired_cnt_q;
	logic                  out_valid_q;
	dstq_pkg::rsp_t        out_q;

	logic [TIME_WIDTH+FW-1:0] tv_ext;
	logic [FW+TIME_WIDTH-1:0] head_ext;
	logic [TIME_WIDTH:0]      sum;
	logic [TIME_WIDTH-1:0]    sat_sum;
	logic [QUEUE_DEPTH-1:0]   valid, match, after, keep;
	logic                     any_match;
	logic                     acc;

	// input time resized to the clock width
	assign tv_ext   = {{TIME_WIDTH{1'b0}}, req.time_value};
	assign head_ext = {{FW{1'b0}}, dl_q[0]};

	// saturating add of clock and request time
	assign sum     = {1'b0, time_q} + {1'b0, req_tv_q};
	assign sat_sum = sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];

	// per-entry match and order flags
	always_comb begin
		acc = 1'b0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			valid[i] = CNT_W'(i) < count_q;
			match[i] = valid[i] && (id_q[i] == req_id_q);
			acc      = acc | match[i];
			after[i] = acc;
			keep[i]  = valid[i] && (dl_q[i] <= sched_dl_q);
		end
		any_match = acc;
	end

	assign stat.head_due  = (count_q != '0) && (dl_q[0] <= time_q)
		&& (fired_cnt_q != FC_W'(dstq_pkg::MAX_FIRED));
	assign stat.emit_last = fired_cnt_q <= FC_W'(1);

	// queue cells
	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (cmd.remove && after[i] && i < QUEUE_DEPTH - 1) begin
				dl_q[i] <= dl_q[(i + 1) % QUEUE_DEPTH];
				id_q[i] <= id_q[(i + 1) % QUEUE_DEPTH];
			end else if (cmd.pop && i < QUEUE_DEPTH - 1) begin
				dl_q[i] <= dl_q[(i + 1) % QUEUE_DEPTH];
				id_q[i] <= id_q[(i + 1) % QUEUE_DEPTH];
			end else if (cmd.insert && count_q < CNT_W'(QUEUE_DEPTH) && !keep[i]) begin
				if (i == 0 || keep[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH]) begin
					dl_q[i] <= sched_dl_q;
					id_q[i] <= req_id_q;
				end else begin
					dl_q[i] <= dl_q[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
					id_q[i] <= id_q[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
				end
			end
		end
	end

	// request capture and deadline
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= req.kind;
			req_id_q <= req.task_id;
			req_tv_q <= tv_ext[TIME_WIDTH-1:0];
		end
		if (cmd.remove) begin
			sched_dl_q <= (kind_q == dstq_pkg::KIND_REL) ? sat_sum : req_tv_q;
		end
	end

	// fired id buffer, read at the head
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			fired_q[fired_cnt_q[FC_W-2:0]] <= id_q[0];
		end else if (cmd.emit) begin
			for (int i = 0; i < dstq_pkg::MAX_FIRED - 1; i++) begin
				fired_q[i] <= fired_q[i + 1];
			end
		end
	end

	// count, clock and fired count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			time_q      <= '0;
			fired_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.emit;
			if (cmd.remove && any_match) begin
				count_q <= count_q - CNT_W'(1);
			end else if (cmd.insert && count_q < CNT_W'(QUEUE_DEPTH)) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.advance) begin
				time_q <= sat_sum;
			end
			if (cmd.load) begin
				fired_cnt_q <= '0;
			end else if (cmd.pop) begin
				fired_cnt_q <= fired_cnt_q + FC_W'(1);
			end else if (cmd.emit && fired_cnt_q != '0) begin
				fired_cnt_q <= fired_cnt_q - FC_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.fired_valid   <= fired_cnt_q != '0;
			out_q.fired_task    <= (fired_cnt_q != '0) ? fired_q[0] : '0;
			out_q.last          <= fired_cnt_q <= FC_W'(1);
			out_q.next_deadline <= (count_q != '0) ? head_ext[FW-1:0] : '0;
			out_q.queue_empty   <= count_q == '0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

### hw/rtl/dstq_checker.sv
`include "deadline_sorted_timer_queue_top_assert.svh"

module dstq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              result_valid,
	input dstq_pkg::rsp_t    result
);

	// a status result always closes its request
	`DSTQ_ASSERT_NOW(a_status_last, result_valid && !result.fired_valid, result.last)

	// no task reported without a fire
	`DSTQ_ASSERT_NOW(a_idle_task, result_valid && !result.fired_valid, result.fired_task == '0)

	// empty queue has no deadline
	`DSTQ_ASSERT_NOW(a_empty_dl, result_valid && result.queue_empty, result.next_deadline == '0)

	// accepted request makes the block busy
	`DSTQ_ASSERT_NEXT(a_busy, start && !busy, busy)

endmodule

bind deadline_sorted_timer_queue_top dstq_checker u_dstq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);
